// ===== src/heightmap_box_smooth_3x3_unit_assert.svh =====
// assertion macros shared by the checker
`ifndef HEIGHTMAP_BOX_SMOOTH_3X3_UNIT_ASSERT_SVH
`define HEIGHTMAP_BOX_SMOOTH_3X3_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define HBS3_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define HBS3_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/hbs3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hbs3_pkg;
  localparam int MAX_WIDTH    = 1024;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int HEIGHT_LIMIT = 4096;
  localparam int DATA_W       = 16;

  // floor(2^23 / d) reciprocals, result corrected by one compare
  localparam logic [15:0] RECIP_255 = 16'd32896;
  localparam logic [20:0] RECIP_9   = 21'd932067;
  localparam logic [20:0] RECIP_6   = 21'd1398101;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_HEIGHT   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RECIP,
    ST_UPD,
    ST_SUM,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== src/hbs3_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hbs3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[addr];
    end
  end
endmodule
`default_nettype wire

// ===== src/heightmap_box_smooth_3x3_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 3x3 edge-normalized box smoother for a raster height map. Each input beat is
// one raw byte, scaled to UQ12.4 as round(byte*max_height/255); each output beat
// is the rounded mean of the in-frame 3x3 neighbors of one sample (divide by 9,
// 6 or 4). The result for (r-1, c-1) leaves when (r, c) enters; a row end adds
// the last column, and in the last row each result of row H-2 is followed by
// the one below it, so a beat gives 0, 1, 2 or 4 results; tlast marks the final
// result of a beat and tuser the frame's bottom-right sample. One beat is worked
// at a time: the line-buffer read, scaling multiply and read-modify-write of
// the two single-port line memories, then for each result the window sum,
// reciprocal multiply, correction and output beat, which waits on out_tready.
// Writing frame_width or frame_height restarts the frame.
module heightmap_box_smooth_3x3_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] raw_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,   // [15:0] smoothed_height
  output logic             out_tlast,
  output logic             out_tuser,   // [0] end_of_frame
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam int AW = hbs3_pkg::ADDR_W;
  localparam int DW = hbs3_pkg::DATA_W;

  hbs3_pkg::state_t state_r, state_nxt;

  logic [10:0]   frame_width_r;
  logic [12:0]   frame_height_r;
  logic [15:0]   max_height_r;
  logic [AW-1:0] col_r;
  logic [11:0]   row_r;
  logic [7:0]    raw_r;
  logic [23:0]   x_r;
  logic [39:0]   p_r;
  logic [DW-1:0] win_r [9];
  logic          top_r, left_r;
  logic [3:0]    pend_r;
  logic          sel_r0_r, sel_c0_r, sel_last_r, sel_eof_r;
  logic [19:0]   s_r;
  logic [40:0]   p2_r;
  logic [15:0]   out_data_r;
  logic          out_last_r, out_eof_r;

  logic          accept, out_fire, cfg_wr, geo_wr;
  logic [1:0]    cfg_idx;
  logic [AW-1:0] wm1;
  logic [11:0]   hm1;
  logic          last_col, last_row;
  logic [DW-1:0] above_rd, two_rd;
  logic [16:0]   hq0;
  logic [24:0]   hrem;
  logic [DW-1:0] hv;
  logic [3:0]    pend_upd;
  logic [1:0]    cur;
  logic          cur_r0, cur_c0;
  logic [3:0]    pend_left;
  logic [19:0]   wsum;
  logic [2:0]    half;
  logic [20:0]   recip;
  logic [17:0]   q0;
  logic [3:0]    nval;
  logic [21:0]   nprod;
  logic [21:0]   rem;
  logic [17:0]   qfin;

  assign accept   = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign cfg_idx  = cfg_paddr[3:2];
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign geo_wr   = cfg_wr && (cfg_idx == hbs3_pkg::REG_FRAME_WIDTH ||
                               cfg_idx == hbs3_pkg::REG_FRAME_HEIGHT);
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      hbs3_pkg::REG_FRAME_WIDTH:  cfg_prdata = {21'd0, frame_width_r};
      hbs3_pkg::REG_FRAME_HEIGHT: cfg_prdata = {19'd0, frame_height_r};
      hbs3_pkg::REG_MAX_HEIGHT:   cfg_prdata = {16'd0, max_height_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // clamped geometry, kept as last index
  always_comb begin
    if (frame_width_r < 11'd2) begin
      wm1 = AW'(1);
    end else if (frame_width_r > 11'(hbs3_pkg::MAX_WIDTH)) begin
      wm1 = AW'(hbs3_pkg::MAX_WIDTH - 1);
    end else begin
      wm1 = AW'(frame_width_r - 11'd1);
    end
    if (frame_height_r < 13'd2) begin
      hm1 = 12'd1;
    end else if (frame_height_r > 13'(hbs3_pkg::HEIGHT_LIMIT)) begin
      hm1 = 12'(hbs3_pkg::HEIGHT_LIMIT - 1);
    end else begin
      hm1 = 12'(frame_height_r - 13'd1);
    end
  end

  assign last_col = (col_r == wm1);
  assign last_row = (row_r == hm1);

  hbs3_ram #(.WIDTH(DW), .DEPTH(hbs3_pkg::MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (state_r == hbs3_pkg::ST_UPD),
    .re    (accept),
    .addr  (col_r),
    .wdata (hv),
    .rdata (above_rd)
  );

  hbs3_ram #(.WIDTH(DW), .DEPTH(hbs3_pkg::MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (state_r == hbs3_pkg::ST_UPD),
    .re    (accept),
    .addr  (col_r),
    .wdata (above_rd),
    .rdata (two_rd)
  );

  // x/255 from the reciprocal product, one step short at most
  always_comb begin
    hq0  = p_r[39:23];
    hrem = {1'b0, x_r} - (({8'd0, hq0} << 8) - {8'd0, hq0});
    hv   = (hrem >= 25'd255) ? DW'(hq0 + 17'd1) : DW'(hq0);
  end

  always_comb begin
    pend_upd[0] = (row_r != '0) && (col_r != '0);
    pend_upd[1] = (row_r != '0) && (col_r != '0) && last_row;
    pend_upd[2] = (row_r != '0) && last_col;
    pend_upd[3] = (row_r != '0) && last_col && last_row;
  end

  // lowest pending result; odd ones are the row below, upper two the last column
  always_comb begin
    if (pend_r[0]) begin
      cur = 2'd0;
    end else if (pend_r[1]) begin
      cur = 2'd1;
    end else if (pend_r[2]) begin
      cur = 2'd2;
    end else begin
      cur = 2'd3;
    end
    cur_r0    = cur[0] ? 1'b1 : top_r;
    cur_c0    = cur[1] ? 1'b1 : left_r;
    pend_left = pend_r & ~(4'd1 << cur);
  end

  always_comb begin
    wsum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((i != 0 || !cur_r0) && (j != 0 || !cur_c0)) begin
          wsum = wsum + 20'(win_r[i*3+j]);
        end
      end
    end
    case ({cur_r0, cur_c0})
      2'b00:   half = 3'd4;
      2'b11:   half = 3'd2;
      default: half = 3'd3;
    endcase
  end

  always_comb begin
    recip = (sel_r0_r || sel_c0_r) ? hbs3_pkg::RECIP_6 : hbs3_pkg::RECIP_9;
    nval  = (sel_r0_r || sel_c0_r) ? 4'd6 : 4'd9;
    q0    = p2_r[40:23];
    nprod = 22'(q0) * 22'(nval);
    rem   = {2'b0, s_r} - nprod;
    if (sel_r0_r && sel_c0_r) begin
      qfin = 18'(s_r >> 2);
    end else if (rem >= 22'(nval)) begin
      qfin = q0 + 18'd1;
    end else begin
      qfin = q0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hbs3_pkg::ST_IDLE:  if (accept) state_nxt = hbs3_pkg::ST_SCALE;
      hbs3_pkg::ST_SCALE: state_nxt = hbs3_pkg::ST_RECIP;
      hbs3_pkg::ST_RECIP: state_nxt = hbs3_pkg::ST_UPD;
      hbs3_pkg::ST_UPD: begin
        state_nxt = (pend_upd != '0) ? hbs3_pkg::ST_SUM : hbs3_pkg::ST_IDLE;
      end
      hbs3_pkg::ST_SUM:   state_nxt = hbs3_pkg::ST_DIV;
      hbs3_pkg::ST_DIV:   state_nxt = hbs3_pkg::ST_FIX;
      hbs3_pkg::ST_FIX:   state_nxt = hbs3_pkg::ST_OUT;
      hbs3_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = (pend_r != '0) ? hbs3_pkg::ST_SUM : hbs3_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hbs3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == hbs3_pkg::ST_IDLE);
    out_tvalid = (state_r == hbs3_pkg::ST_OUT);
    out_tdata  = out_data_r;
    out_tlast  = out_last_r;
    out_tuser  = out_eof_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= hbs3_pkg::ST_IDLE;
      frame_width_r  <= 11'd256;
      frame_height_r <= 13'd256;
      max_height_r   <= 16'd4096;
      col_r          <= '0;
      row_r          <= '0;
      pend_r         <= '0;
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          hbs3_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[10:0];
          hbs3_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[12:0];
          hbs3_pkg::REG_MAX_HEIGHT:   max_height_r   <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (geo_wr) begin
        col_r <= '0;
        row_r <= '0;
        for (int k = 0; k < 9; k++) win_r[k] <= '0;
      end else if (state_r == hbs3_pkg::ST_UPD) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i*3]   <= win_r[i*3+1];
          win_r[i*3+1] <= win_r[i*3+2];
        end
        win_r[2] <= two_rd;
        win_r[5] <= above_rd;
        win_r[8] <= hv;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 12'd1;
        end else begin
          col_r <= col_r + AW'(1);
        end
      end
      if (state_r == hbs3_pkg::ST_UPD) begin
        pend_r <= pend_upd;
      end else if (state_r == hbs3_pkg::ST_SUM) begin
        pend_r <= pend_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r <= in_tdata;
    end
    x_r  <= 24'(raw_r) * 24'(max_height_r) + 24'd127;
    p_r  <= 40'(x_r) * 40'(hbs3_pkg::RECIP_255);
    p2_r <= 41'(s_r) * 41'(recip);
    if (state_r == hbs3_pkg::ST_UPD) begin
      top_r  <= (row_r < 12'd2);
      left_r <= (col_r < AW'(2));
    end
    if (state_r == hbs3_pkg::ST_SUM) begin
      s_r        <= wsum + 20'(half);
      sel_r0_r   <= cur_r0;
      sel_c0_r   <= cur_c0;
      sel_last_r <= (pend_left == '0);
      sel_eof_r  <= (cur == 2'd3);
    end
    if (state_r == hbs3_pkg::ST_FIX) begin
      out_data_r <= qfin[15:0];
      out_last_r <= sel_last_r;
      out_eof_r  <= sel_eof_r;
    end
  end
endmodule
`default_nettype wire

// ===== src/hbs3_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "heightmap_box_smooth_3x3_unit_assert.svh"
module hbs3_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);
  // stalled output beat keeps its payload
  `HBS3_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // one beat in work at a time: no intake while a result is offered
  `HBS3_ASSERT_NOW(a_no_overlap, clk, rst_n, out_tvalid, !in_tready)
  // the frame's final result is always the last of its beat
  `HBS3_ASSERT_NOW(a_eof_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  // an accepted beat closes intake for the next cycle
  `HBS3_ASSERT_NEXT(a_busy_after, clk, rst_n, in_tvalid && in_tready, !in_tready)
endmodule

bind heightmap_box_smooth_3x3_unit hbs3_checker u_hbs3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire
